// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the mesh container validator.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define MCV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset cycles included.
`define MCV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mcv_pkg.sv
// Package of the mesh container validator: status codes, beat and result structs,
// layout constants and small helper functions. Depends on nothing.
package mcv_pkg;

    localparam int POS_W        = 40;
    localparam int HDR_BYTES    = 24;
    localparam int VERTEX_BYTES = 40;
    localparam int MAGIC_BYTES  = 8;

    // Header positions: each word's last byte, plus the index word's first byte.
    localparam logic [4:0] POS_VERSION_END = 5'd11;
    localparam logic [4:0] POS_MESHES_END  = 5'd15;
    localparam logic [4:0] POS_VERTS_END   = 5'd19;
    localparam logic [4:0] POS_VERTS_NEXT  = 5'd20;
    localparam logic [4:0] POS_INDICES_END = 5'd23;

    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HDR_BYTES - 1);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TRUNC   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_OFFSETS = 3'd4,
        ST_FLOAT   = 3'd5,
        ST_INDEX   = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        logic        valid_res;
        t_status     status;
        logic [31:0] mesh_count;
        logic [31:0] vertex_count;
        logic [31:0] index_count;
    } t_verdict;

    // Expected magic: the ASCII text of the format tag followed by a zero byte.
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] m;
        case (idx)
            3'd0:    m = "R";
            3'd1:    m = "R";
            3'd2:    m = "M";
            3'd3:    m = "E";
            3'd4:    m = "S";
            3'd5:    m = "H";
            3'd6:    m = "1";
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Since 4 is 1 modulo 3, a byte is congruent to the sum of its base-4 digits.
    function automatic logic [1:0] byte_mod3(input logic [7:0] b);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd6) begin
            return 2'd0;
        end else if (t >= 3'd3) begin
            return 2'(t - 3'd3);
        end
        return t[1:0];
    endfunction

    function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = 3'(a) + 3'(b);
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

endpackage

// File: rtl/mcv_if.sv
// Channel interfaces of the mesh container validator: the byte input channel and
// the result channel, each with valid/ready. Depends on nothing.
interface mcv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mcv_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [2:0]  status;
    logic [31:0] mesh_count;
    logic [31:0] vertex_count;
    logic [31:0] index_count;

    modport source (output valid, output valid_res, output status, output mesh_count,
                    output vertex_count, output index_count, input ready);
    modport sink   (input valid, input valid_res, input status, input mesh_count,
                    input vertex_count, input index_count, output ready);
endinterface

// File: rtl/mcv_in_stage.sv
// Input register of the mesh container validator: holds one byte beat until the
// check core takes it. Depends on mcv_pkg.
module mcv_in_stage import mcv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_beat i_beat,
    input  logic  i_adv,
    output logic  o_ready,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    logic  n_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_adv;
    assign n_valid = i_valid ? 1'b1 : (r_valid && !i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// File: rtl/mcv_core.sv
// Check core of the mesh container validator: stream position, header capture,
// section bounds and the per-word checks, plus the verdict of the final byte.
// Depends on mcv_pkg.
module mcv_core import mcv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_beat    i_beat,
    output t_verdict o_verdict
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [23:0]      r_gather, n_gather;
    logic [1:0]       r_gather_m3, n_gather_m3;
    logic [31:0]      r_meshes_seen, n_meshes_seen;
    logic [31:0]      r_prev_off, n_prev_off;
    logic [1:0]       r_prev_m3, n_prev_m3;
    logic [POS_W-1:0] r_vertex_start, n_vertex_start;
    logic [POS_W-1:0] r_index_start, n_index_start;
    logic [POS_W-1:0] r_total_end, n_total_end;
    logic [5:0]       r_byte_in_vtx, n_byte_in_vtx;
    t_status          r_first_error, n_first_error;
    logic [31:0]      r_hdr_meshes, n_hdr_meshes;
    logic [31:0]      r_hdr_vertices, n_hdr_vertices;
    logic [31:0]      r_hdr_indices, n_hdr_indices;

    logic [7:0]  b;
    logic [1:0]  lane;
    logic        word_done;
    logic [31:0] word;
    logic [1:0]  b_m3;
    logic [1:0]  word_m3;
    logic        no_error;
    logic        flag;
    t_status     flag_code;
    logic [3:0]  vtx_word;
    logic [POS_W:0] size;
    logic        end_beyond;
    t_status     status;

    assign b         = i_beat.data_byte;
    assign lane      = r_pos[1:0];
    assign word_done = (lane == 2'd3);
    assign word      = {b, r_gather};
    assign b_m3      = byte_mod3(b);
    assign word_m3   = add_mod3(r_gather_m3, b_m3);
    assign no_error  = (r_first_error == ST_OK);
    assign vtx_word  = r_byte_in_vtx[5:2];

    always_comb begin
        n_pos          = r_pos;
        n_gather       = r_gather;
        n_gather_m3    = r_gather_m3;
        n_meshes_seen  = r_meshes_seen;
        n_prev_off     = r_prev_off;
        n_prev_m3      = r_prev_m3;
        n_vertex_start = r_vertex_start;
        n_index_start  = r_index_start;
        n_total_end    = r_total_end;
        n_byte_in_vtx  = r_byte_in_vtx;
        n_hdr_meshes   = r_hdr_meshes;
        n_hdr_vertices = r_hdr_vertices;
        n_hdr_indices  = r_hdr_indices;
        flag           = 1'b0;
        flag_code      = ST_OK;

        case (lane)
            2'd0: begin
                n_gather    = {16'h0000, b};
                n_gather_m3 = b_m3;
            end
            2'd1: begin
                n_gather    = r_gather | {8'h00, b, 8'h00};
                n_gather_m3 = word_m3;
            end
            2'd2: begin
                n_gather    = r_gather | {b, 16'h0000};
                n_gather_m3 = word_m3;
            end
            default: begin
                n_gather    = r_gather;
                n_gather_m3 = r_gather_m3;
            end
        endcase

        if (r_pos < POS_W'(MAGIC_BYTES)) begin
            flag      = (b != magic_byte(r_pos[2:0]));
            flag_code = ST_MAGIC;
        end else if (r_pos < POS_W'(HDR_BYTES)) begin
            // Section bounds are built up across the header so that each step
            // needs only one wide add.
            if (word_done && r_pos[4:0] == POS_VERSION_END) begin
                flag      = (word != 32'd1);
                flag_code = ST_VERSION;
            end
            if (word_done && r_pos[4:0] == POS_MESHES_END) begin
                n_hdr_meshes   = word;
                n_vertex_start = POS_W'(HDR_BYTES + 4) + {6'b0, word, 2'b00};
            end
            if (word_done && r_pos[4:0] == POS_VERTS_END) begin
                n_hdr_vertices = word;
                n_index_start  = r_vertex_start + {3'b0, word, 5'b00000};
            end
            if (r_pos[4:0] == POS_VERTS_NEXT) begin
                n_index_start = r_index_start + {5'b0, r_hdr_vertices, 3'b000};
            end
            if (word_done && r_pos[4:0] == POS_INDICES_END) begin
                n_hdr_indices = word;
                n_total_end   = r_index_start + {6'b0, word, 2'b00};
            end
        end else if (r_pos < r_vertex_start) begin
            if (word_done && no_error) begin
                // Once the word is not below the previous offset, the step is a
                // multiple of three exactly when both residues agree.
                if (r_meshes_seen == 32'd0) begin
                    flag = (word != 32'd0);
                end else begin
                    flag = (word < r_prev_off) || (word > r_hdr_indices) ||
                           (word_m3 != r_prev_m3);
                end
                if (r_meshes_seen == r_hdr_meshes && word != r_hdr_indices) begin
                    flag = 1'b1;
                end
                flag_code     = ST_OFFSETS;
                n_prev_off    = word;
                n_prev_m3     = word_m3;
                n_meshes_seen = r_meshes_seen + 32'd1;
            end
        end else if (r_pos < r_index_start) begin
            // Position and normal occupy words 0 to 5, the uv pair words 7 and 8.
            if (word_done && no_error &&
                (vtx_word < 4'd6 || vtx_word == 4'd7 || vtx_word == 4'd8)) begin
                flag      = &word[30:23];
                flag_code = ST_FLOAT;
            end
            if (r_byte_in_vtx == 6'(VERTEX_BYTES - 1)) begin
                n_byte_in_vtx = 6'd0;
            end else begin
                n_byte_in_vtx = r_byte_in_vtx + 6'd1;
            end
        end else if (r_pos < r_total_end) begin
            if (word_done && no_error) begin
                flag      = (word >= r_hdr_vertices);
                flag_code = ST_INDEX;
            end
        end

        if (r_pos != POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end

        n_first_error = (no_error && flag) ? flag_code : r_first_error;
    end

    // Verdict of a final byte. When the final byte closes the header the end
    // bound is only being formed now, but it always lies beyond the header.
    assign size       = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign end_beyond = (r_pos == POS_HDR_LAST) || ({1'b0, r_total_end} > size);

    always_comb begin
        if (r_pos < POS_HDR_LAST) begin
            status = ST_TRUNC;
        end else if (n_first_error == ST_MAGIC || n_first_error == ST_VERSION) begin
            status = n_first_error;
        end else if (end_beyond) begin
            status = ST_TRUNC;
        end else begin
            status = n_first_error;
        end
    end

    always_comb begin
        o_verdict.valid_res    = (status == ST_OK);
        o_verdict.status       = status;
        o_verdict.mesh_count   = (status == ST_OK) ? r_hdr_meshes : 32'd0;
        o_verdict.vertex_count = (status == ST_OK) ? r_hdr_vertices : 32'd0;
        o_verdict.index_count  = (status == ST_OK) ? r_hdr_indices : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_beat.last_byte)) begin
            r_pos          <= '0;
            r_gather       <= '0;
            r_gather_m3    <= '0;
            r_meshes_seen  <= '0;
            r_prev_off     <= '0;
            r_prev_m3      <= '0;
            r_vertex_start <= '0;
            r_index_start  <= '0;
            r_total_end    <= '0;
            r_byte_in_vtx  <= '0;
            r_first_error  <= ST_OK;
            r_hdr_meshes   <= '0;
            r_hdr_vertices <= '0;
            r_hdr_indices  <= '0;
        end else if (i_adv) begin
            r_pos          <= n_pos;
            r_gather       <= n_gather;
            r_gather_m3    <= n_gather_m3;
            r_meshes_seen  <= n_meshes_seen;
            r_prev_off     <= n_prev_off;
            r_prev_m3      <= n_prev_m3;
            r_vertex_start <= n_vertex_start;
            r_index_start  <= n_index_start;
            r_total_end    <= n_total_end;
            r_byte_in_vtx  <= n_byte_in_vtx;
            r_first_error  <= n_first_error;
            r_hdr_meshes   <= n_hdr_meshes;
            r_hdr_vertices <= n_hdr_vertices;
            r_hdr_indices  <= n_hdr_indices;
        end
    end

endmodule

// File: rtl/mcv_out_stage.sv
// Result register of the mesh container validator: holds one verdict until the
// receiver takes it. Depends on mcv_pkg.
module mcv_out_stage import mcv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_verdict i_verdict,
    input  logic     i_ready,
    output logic     o_valid,
    output t_verdict o_verdict
);

    logic     r_valid;
    logic     n_valid;
    t_verdict r_verdict;

    assign n_valid = i_load ? 1'b1 : (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

// File: rtl/mesh_container_validator_unit.sv
// Top level of the mesh container validator: input register, check core and
// result register. Depends on mcv_pkg, mcv_if, mcv_in_stage, mcv_core, mcv_out_stage.
//
// Usage: a container enters on i_byte one byte per beat in file order, with
// last_byte set on the final beat of the buffer. Exactly one result beat leaves
// on o_res for each final byte; other bytes give no result. The result carries
// valid_res, the status code and the three header counts, which read zero
// unless the container passed every check.
// Throughput: one byte per cycle for streams of any length, sustained while each
// final byte finds the result register free; a new container may start on the
// beat right after a final byte. Path: a byte is registered in the input register
// and checked there by the core; a final byte's result is loaded into the result
// register when o_res is free and leaves on o_res from that register.
// Reset: a synchronous active-low reset empties both registers and clears the
// stream position, the error record and the header counts. The same clearing
// happens inside the core after every final byte.
// Stalls: while o_res waits, non-final bytes keep flowing through the core;
// only a final byte waits in the input register until the result register is
// free, and i_byte.ready then drops until it moves on.
module mesh_container_validator_unit import mcv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mcv_byte_if.sink  i_byte,
    mcv_res_if.source o_res
);

    t_beat    in_beat;
    t_beat    stage_beat;
    logic     stage_valid;
    logic     out_free;
    logic     adv;
    t_verdict core_verdict;
    t_verdict out_verdict;
    logic     out_valid;

    assign in_beat.data_byte = i_byte.data_byte;
    assign in_beat.last_byte = i_byte.last_byte;

    // A byte held in the input register moves into the core every cycle; a final byte needs a free result slot.
    assign out_free = !out_valid || o_res.ready;
    assign adv      = stage_valid && (!stage_beat.last_byte || out_free);

    mcv_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .i_beat  (in_beat),
        .i_adv   (adv),
        .o_ready (i_byte.ready),
        .o_valid (stage_valid),
        .o_beat  (stage_beat)
    );

    mcv_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_beat    (stage_beat),
        .o_verdict (core_verdict)
    );

    mcv_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (adv && stage_beat.last_byte),
        .i_verdict (core_verdict),
        .i_ready   (o_res.ready),
        .o_valid   (out_valid),
        .o_verdict (out_verdict)
    );

    assign o_res.valid        = out_valid;
    assign o_res.valid_res    = out_verdict.valid_res;
    assign o_res.status       = out_verdict.status;
    assign o_res.mesh_count   = out_verdict.mesh_count;
    assign o_res.vertex_count = out_verdict.vertex_count;
    assign o_res.index_count  = out_verdict.index_count;

endmodule

// File: rtl/mcv_sva.sv
// Port-level assertions of the mesh container validator and their bind to the top
// level. Depends on mcv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcv_sva import mcv_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_valid_res,
    input logic [2:0]  i_status,
    input logic [31:0] i_mesh_count,
    input logic [31:0] i_vertex_count,
    input logic [31:0] i_index_count
);

    `MCV_ASSERT(a_pass_matches_status, i_clk, i_rst_n, i_res_valid |-> (i_valid_res == (i_status == ST_OK)), "valid_res disagrees with status")
    `MCV_ASSERT(a_counts_zero_on_fail, i_clk, i_rst_n, (i_res_valid && i_status != ST_OK) |-> (i_mesh_count == 32'd0 && i_vertex_count == 32'd0 && i_index_count == 32'd0), "counts not zero on a failed container")
    `MCV_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_res_valid, "result beat present after reset")
    `MCV_ASSERT(a_stall_holds, i_clk, i_rst_n, (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_status) && $stable(i_index_count)), "stalled result beat changed")

endmodule

bind mesh_container_validator_unit mcv_sva u_mcv_sva (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_valid_res    (o_res.valid_res),
    .i_status       (o_res.status),
    .i_mesh_count   (o_res.mesh_count),
    .i_vertex_count (o_res.vertex_count),
    .i_index_count  (o_res.index_count)
);
